>>> rtl/core/ttd_pkg.sv
package ttd_pkg;

   localparam int unsigned SUSTAIN_MS  = 200;
   localparam int unsigned TAPS_NEEDED = 3;

   localparam int unsigned AXIS_W   = 15;
   localparam int unsigned MAG_W    = 15;
   localparam int unsigned LEVEL_W  = 23;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned REQ_W    = 80;
   localparam int unsigned RSP_W    = 192;
   localparam int unsigned CSR_IX_W = 3;
   localparam int unsigned CSR_D_W  = 16;

   typedef enum logic [1:0] {
      OP_SAMPLE      = 2'd0,
      OP_SEQ_CLEAR   = 2'd1,
      OP_STATS_CLEAR = 2'd2,
      OP_NONE        = 2'd3
   } ttd_op_type;

   typedef enum logic [CSR_IX_W-1:0] {
      REG_TAP_THR   = 3'd0,
      REG_WINDOW    = 3'd1,
      REG_MIN_GAP   = 3'd2,
      REG_MAX_GAP   = 3'd3,
      REG_DEBOUNCE  = 3'd4,
      REG_VIB_ON    = 3'd5,
      REG_VIB_THR   = 3'd6,
      REG_UNUSED    = 3'd7
   } ttd_reg_type;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_FIRST    = 2'd1,
      PH_SECOND   = 2'd2,
      PH_DEBOUNCE = 2'd3
   } ttd_phase_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SQUARE,
      S_ROOT,
      S_LEVEL_LOAD,
      S_LEVEL,
      S_DECIDE,
      S_MULT,
      S_MEAN_LOAD,
      S_DIVIDE,
      S_OUTPUT
   } ttd_state_type;

   function automatic logic [AXIS_W-1:0] abs15(input logic [AXIS_W-1:0] v);
      logic [AXIS_W:0] m;
      m = {1'b1, {AXIS_W{1'b0}}} - {1'b0, v};
      return v[AXIS_W-1] ? m[AXIS_W-1:0] : v;
   endfunction

endpackage

>>> rtl/core/triple_tap_detector_core.sv
// Channel | Direction | Handshake           | Payload
// req     | in        | req_tvalid/tready   | tuser opcode, tdata axes and time
// rsp     | out       | rsp_tvalid/tready   | tdata state, flags and statistics
// csr     | in        | csr_valid/ready     | csr_index, csr_data
//
// A sample runs the sum of squares, the square root, a level load, the divide by
// ten of the vibration level and the decision; a taken tap adds the mean update.
// Output and idle end every transaction; a sequence or statistics opcode goes from
// idle straight to the output. Reset is synchronous and active high; it restores
// configuration, control, detection and statistics state, but not the datapath.
// Register writes are taken only between transactions and hold off req_tready.
// A stalled result waits in an output register while the next transaction runs; a
// second finished result then waits for that register with req_tready low.
module triple_tap_detector_core
   import ttd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [1:0]          req_tuser,   // opcode
   input  logic [REQ_W-1:0]    req_tdata,   // axis_x, axis_y, axis_z, now_ms, zero pad
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // detect_state, taps_in_sequence, tap_taken, tap_axes, triple_tap,
   // vibration_rejected, total_tap_count, false_positive_count, triple_total,
   // vibration_event_count, mean_tap_magnitude, last_triple_time, zero pad
   output logic [RSP_W-1:0]    rsp_tdata,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CSR_IX_W-1:0] csr_index,
   input  logic [CSR_D_W-1:0]  csr_data
);

   // Configuration registers.
   logic [14:0] tap_thr_ff, vib_thr_ff;
   logic [15:0] window_ff, min_gap_ff, max_gap_ff, debounce_ff;
   logic        vib_on_ff;

   // Detection and statistics state.
   logic [1:0]        phase_ff, tapn_ff;
   logic [TIME_W-1:0] start_ff, prev_ff, quiet_ff, since_ff;
   logic [LEVEL_W-1:0] level_ff;
   logic              timing_ff;
   logic [31:0]       taps_ff, false_ff, triples_ff, vib_total_ff, last_ff;
   logic [MAG_W-1:0]  mean_ff;

   // Datapath of the current transaction.
   ttd_state_type     state_ff, state_in;
   logic [4:0]        cnt_ff;
   logic [AXIS_W-1:0] ax_ff, ay_ff, az_ff;
   logic [TIME_W-1:0] now_ff;
   logic [29:0]       sq_ff, n_ff;
   logic [30:0]       root_ff, bit_ff;
   logic [26:0]       dnum_ff, dq_ff;
   logic [3:0]        drem_ff;
   logic [46:0]       prod_ff;
   logic [31:0]       mrem_ff;
   logic [14:0]       mlo_ff, mq_ff;
   logic              taken_ff, triple_ff, rej_ff;
   logic [2:0]        axes_ff;
   logic              rsp_tvalid_ff;
   logic [RSP_W-1:0]  rsp_tdata_ff;

   logic              accept, rsp_load;

   // Decision results.
   logic [1:0]        phase_in, tapn_in;
   logic [TIME_W-1:0] start_in, prev_in, quiet_in, since_in, last_in;
   logic              timing_in, take_in, trip_in, rej_in, go;
   logic [31:0]       taps_in, false_in, triples_in, vib_total_in, gap;
   logic [2:0]        axes_in;

   logic [MAG_W-1:0]  mag;
   logic [LEVEL_W-1:0] lvl_new;
   logic [AXIS_W-1:0] sq_sel;
   logic [30:0]       rb;
   logic [4:0]        dsh;
   logic [32:0]       msh;
   logic [46:0]       mnum;

   assign mag     = root_ff[MAG_W-1:0];
   assign lvl_new = dq_ff[LEVEL_W-1:0];
   assign rb      = root_ff + bit_ff;
   assign dsh     = {drem_ff, dnum_ff[26]};
   assign msh     = {mrem_ff, mlo_ff[14]};
   assign mnum    = prod_ff + {32'd0, mag};

   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    sq_sel = ax_ff;
         2'd1:    sq_sel = ay_ff;
         default: sq_sel = az_ff;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:
            if (accept) begin
               state_in = (ttd_op_type'(req_tuser) == OP_SAMPLE) ? S_SQUARE : S_OUTPUT;
            end
         S_SQUARE:     if (cnt_ff == 5'd3) state_in = S_ROOT;
         S_ROOT:       if (cnt_ff == 5'd15) state_in = S_LEVEL_LOAD;
         S_LEVEL_LOAD: state_in = S_LEVEL;
         S_LEVEL:      if (cnt_ff == 5'd26) state_in = S_DECIDE;
         S_DECIDE:     state_in = (take_in && taps_in != 32'd0) ? S_MULT : S_OUTPUT;
         S_MULT:       state_in = S_MEAN_LOAD;
         S_MEAN_LOAD:  state_in = S_DIVIDE;
         S_DIVIDE:     if (cnt_ff == 5'd14) state_in = S_OUTPUT;
         S_OUTPUT:     if (rsp_load) state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   // Handshake outputs. A pending register write goes ahead of a new transaction.
   always_comb begin
      csr_ready  = (state_ff == S_IDLE);
      req_tready = (state_ff == S_IDLE) && !csr_valid;
      rsp_load   = (state_ff == S_OUTPUT) && (!rsp_tvalid_ff || rsp_tready);
   end

   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Sample decision: vibration timing, tap sequence and statistics, all taken
   // from the new vibration level and the magnitude.
   always_comb begin
      phase_in = phase_ff;  tapn_in = tapn_ff;  start_in = start_ff;
      prev_in = prev_ff;    quiet_in = quiet_ff; since_in = since_ff;
      last_in = last_ff;    timing_in = timing_ff;
      taps_in = taps_ff;    false_in = false_ff; triples_in = triples_ff;
      vib_total_in = vib_total_ff;
      take_in = 1'b0; trip_in = 1'b0; rej_in = 1'b0; axes_in = 3'd0; go = 1'b1;
      gap = now_ff - prev_ff;
      if (vib_on_ff) begin
         if (lvl_new > {vib_thr_ff, 8'd0}) begin
            if (!timing_ff) begin
               timing_in = 1'b1;
               since_in  = now_ff;
            end
            if ((now_ff - since_in) > SUSTAIN_MS) begin
               vib_total_in = vib_total_ff + 32'd1;
               rej_in = 1'b1;
               go = 1'b0;
            end
         end else begin
            timing_in = 1'b0;
         end
      end
      if (go && mag >= tap_thr_ff) begin
         if (phase_ff == PH_DEBOUNCE) begin
            if ((now_ff - quiet_ff) < {16'd0, debounce_ff}) begin
               go = 1'b0;
            end else begin
               phase_in = PH_IDLE; tapn_in = 2'd0; start_in = '0; prev_in = '0;
            end
         end
         gap = now_ff - prev_in;
         if (go && tapn_in != 2'd0) begin
            if (gap < {16'd0, min_gap_ff} || gap > {16'd0, max_gap_ff}) begin
               phase_in = PH_IDLE; tapn_in = 2'd0; start_in = '0; prev_in = '0;
               false_in = false_ff + 32'd1;
               go = 1'b0;
            end
         end
         if (go) begin
            take_in = 1'b1;
            axes_in[0] = {ax_ff, 1'b0} > {1'b0, tap_thr_ff};
            axes_in[1] = {ay_ff, 1'b0} > {1'b0, tap_thr_ff};
            axes_in[2] = {az_ff, 1'b0} > {1'b0, tap_thr_ff};
            tapn_in = tapn_in + 2'd1;
            prev_in = now_ff;
            if (tapn_in == 2'd1) begin
               start_in = now_ff;
               phase_in = PH_FIRST;
            end else if (tapn_in == 2'd2) begin
               phase_in = PH_SECOND;
            end
            taps_in = taps_ff + 32'd1;
            if ({30'd0, tapn_in} >= TAPS_NEEDED) begin
               if ((now_ff - start_in) <= {16'd0, window_ff}) begin
                  phase_in   = PH_DEBOUNCE;
                  quiet_in   = now_ff;
                  triples_in = triples_ff + 32'd1;
                  last_in    = now_ff;
                  trip_in    = 1'b1;
               end else begin
                  phase_in = PH_IDLE; tapn_in = 2'd0; start_in = '0; prev_in = '0;
                  false_in = false_ff + 32'd1;
               end
            end else if ((now_ff - start_in) > {16'd0, window_ff}) begin
               phase_in = PH_IDLE; tapn_in = 2'd0; start_in = '0; prev_in = '0;
               false_in = false_ff + 32'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         tap_thr_ff <= 15'd2000; window_ff <= 16'd1000; min_gap_ff <= 16'd50;
         max_gap_ff <= 16'd500; debounce_ff <= 16'd1000; vib_on_ff <= 1'b1;
         vib_thr_ff <= 15'd500;
         phase_ff <= PH_IDLE; tapn_ff <= '0; start_ff <= '0; prev_ff <= '0;
         quiet_ff <= '0; level_ff <= '0; since_ff <= '0; timing_ff <= 1'b0;
         taps_ff <= '0; false_ff <= '0; triples_ff <= '0; vib_total_ff <= '0;
         mean_ff <= '0; last_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               cnt_ff <= '0;
               if (csr_valid) begin
                  // A write to a listed register also restarts the tap sequence.
                  case (ttd_reg_type'(csr_index))
                     REG_TAP_THR:  tap_thr_ff  <= csr_data[14:0];
                     REG_WINDOW:   window_ff   <= csr_data;
                     REG_MIN_GAP:  min_gap_ff  <= csr_data;
                     REG_MAX_GAP:  max_gap_ff  <= csr_data;
                     REG_DEBOUNCE: debounce_ff <= csr_data;
                     REG_VIB_ON:   vib_on_ff   <= csr_data[0];
                     REG_VIB_THR:  vib_thr_ff  <= csr_data[14:0];
                     default: ;
                  endcase
                  if (csr_index != REG_UNUSED) begin
                     phase_ff <= PH_IDLE; tapn_ff <= '0; start_ff <= '0; prev_ff <= '0;
                  end
               end else if (accept) begin
                  ax_ff <= abs15(req_tdata[14:0]);
                  ay_ff <= abs15(req_tdata[29:15]);
                  az_ff <= abs15(req_tdata[44:30]);
                  now_ff <= req_tdata[76:45];
                  n_ff <= '0;
                  root_ff <= '0;
                  bit_ff <= 31'h4000_0000;
                  taken_ff <= 1'b0; triple_ff <= 1'b0; rej_ff <= 1'b0; axes_ff <= '0;
                  case (ttd_op_type'(req_tuser))
                     OP_SEQ_CLEAR: begin
                        phase_ff <= PH_IDLE; tapn_ff <= '0; start_ff <= '0; prev_ff <= '0;
                     end
                     OP_STATS_CLEAR: begin
                        taps_ff <= '0; false_ff <= '0; triples_ff <= '0;
                        vib_total_ff <= '0; mean_ff <= '0; last_ff <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            S_SQUARE: begin
               // One square per cycle, each added to the sum in the next cycle.
               sq_ff <= {15'd0, sq_sel} * {15'd0, sq_sel};
               if (cnt_ff != 5'd0) n_ff <= n_ff + sq_ff;
               cnt_ff <= (cnt_ff == 5'd3) ? 5'd0 : cnt_ff + 5'd1;
            end
            S_ROOT: begin
               if ({1'b0, n_ff} >= rb) begin
                  n_ff    <= n_ff - rb[29:0];
                  root_ff <= (root_ff >> 1) + bit_ff;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               cnt_ff <= (cnt_ff == 5'd15) ? 5'd0 : cnt_ff + 5'd1;
            end
            S_LEVEL_LOAD: begin
               dnum_ff <= {4'd0, mag, 8'd0} + {1'b0, level_ff, 3'd0} + {4'd0, level_ff};
               drem_ff <= '0;
               dq_ff   <= '0;
            end
            S_LEVEL: begin
               // Restoring division by ten, one quotient bit per cycle.
               if (dsh >= 5'd10) begin
                  drem_ff <= 4'(dsh - 5'd10);
                  dq_ff   <= {dq_ff[25:0], 1'b1};
               end else begin
                  drem_ff <= dsh[3:0];
                  dq_ff   <= {dq_ff[25:0], 1'b0};
               end
               dnum_ff <= {dnum_ff[25:0], 1'b0};
               cnt_ff  <= (cnt_ff == 5'd26) ? 5'd0 : cnt_ff + 5'd1;
            end
            S_DECIDE: begin
               level_ff <= lvl_new;
               phase_ff <= phase_in; tapn_ff <= tapn_in; start_ff <= start_in;
               prev_ff <= prev_in; quiet_ff <= quiet_in; since_ff <= since_in;
               timing_ff <= timing_in; last_ff <= last_in;
               taps_ff <= taps_in; false_ff <= false_in; triples_ff <= triples_in;
               vib_total_ff <= vib_total_in;
               taken_ff <= take_in; triple_ff <= trip_in; rej_ff <= rej_in;
               axes_ff <= axes_in;
               // Tap counter wrapped to zero: the mean restarts at this magnitude.
               if (take_in && taps_in == 32'd0) mean_ff <= mag;
            end
            S_MULT: prod_ff <= {32'd0, mean_ff} * {15'd0, taps_ff - 32'd1};
            S_MEAN_LOAD: begin
               // The mean never exceeds 15 bits, so the upper part is below the divisor.
               mrem_ff <= mnum[46:15];
               mlo_ff  <= mnum[14:0];
               mq_ff   <= '0;
            end
            S_DIVIDE: begin
               if (msh >= {1'b0, taps_ff}) begin
                  mrem_ff <= 32'(msh - {1'b0, taps_ff});
                  mq_ff   <= {mq_ff[13:0], 1'b1};
               end else begin
                  mrem_ff <= msh[31:0];
                  mq_ff   <= {mq_ff[13:0], 1'b0};
               end
               mlo_ff <= {mlo_ff[13:0], 1'b0};
               if (cnt_ff == 5'd14) begin
                  mean_ff <= (msh >= {1'b0, taps_ff}) ? {mq_ff[13:0], 1'b1}
                                                      : {mq_ff[13:0], 1'b0};
                  cnt_ff <= '0;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            default: ;
         endcase
      end
   end

   // Result register: loaded only when the previous result has been taken.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_tdata_ff <= {7'd0, last_ff, mean_ff, vib_total_ff, triples_ff, false_ff,
                          taps_ff, rej_ff, triple_ff, axes_ff, taken_ff, tapn_ff,
                          phase_ff};
      end
   end

endmodule

>>> rtl/core/ttd_checker.sv
module ttd_checker
   import ttd_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // A completed triple tap is always a taken tap that enters debounce.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |-> rsp_tdata[4] && rsp_tdata[1:0] == PH_DEBOUNCE)
      else $error("triple tap without taken tap or debounce");

   // A rejected sample is never a tap.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9] |-> !rsp_tdata[4] && !rsp_tdata[8])
      else $error("rejected sample reported as tap");

   // Axis flags appear only with a taken tap.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[7:5] != 3'd0 |-> rsp_tdata[4])
      else $error("axis flags without a tap");

endmodule

bind triple_tap_detector_core ttd_checker u_ttd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
